FILE: rtl/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, constants and helpers of the padded frame rotator.
// ----------------------------------------------------------------------------
package pfr_pkg;

   // register field widths
   localparam int REG_W = 8;
   localparam int BPP_W = 3;

   // geometry and counter widths, settled by the 8 bit dimension registers
   localparam int GEO_W  = 11;
   localparam int COL_W  = 10;
   localparam int ROW_W  = 8;
   localparam int YW     = 10;
   localparam int CALC_W = 24;

   // divide by three of a column index: (col * 683) >> 11 is exact below 1024
   localparam int RECIP3       = 683;
   localparam int RECIP3_SHIFT = 11;

   // configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
   localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd2;

   localparam logic [REG_W-1:0] IMAGE_WIDTH_RESET     = 8'd1;
   localparam logic [REG_W-1:0] IMAGE_HEIGHT_RESET    = 8'd1;
   localparam logic [BPP_W-1:0] BYTES_PER_PIXEL_RESET = 3'd3;

   // parameter defaults
   localparam int MAX_DIMENSION_DEF = 128;
   localparam int FRAME_BYTES_DEF   = 65536;

   typedef struct packed {
      logic [REG_W-1:0] image_width;
      logic [REG_W-1:0] image_height;
      logic [BPP_W-1:0] bytes_per_pixel;
      logic             written;
   } csr_out_type;

   typedef enum logic [1:0] {
      RS_IDLE,
      RS_DIV,
      RS_MUL
   } resync_state_type;

   function automatic logic [REG_W-1:0] clamp_dim(logic [REG_W-1:0] v, int max_dim);
      logic [REG_W-1:0] r;
      if (v == '0) begin
         r = REG_W'(1);
      end else if (32'(v) > max_dim) begin
         r = max_dim[REG_W-1:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [BPP_W-1:0] eff_bpp(logic [BPP_W-1:0] b);
      logic [BPP_W-1:0] r;
      if (b == '0) begin
         r = BPP_W'(1);
      end else if (b > BPP_W'(4)) begin
         r = BPP_W'(4);
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

FILE: rtl/pfr_if.sv
// ----------------------------------------------------------------------------
// pfr_req_if / pfr_rsp_if
// Valid/ready channels of the rotator: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface pfr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] source_byte;

   modport source (output valid, output op, output source_byte, input ready);
   modport sink   (input valid, input op, input source_byte, output ready);
endinterface

interface pfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] rotated_byte;
   logic       last_byte;

   modport source (output valid, output rotated_byte, output last_byte, input ready);
   modport sink   (input valid, input rotated_byte, input last_byte, output ready);
endinterface

FILE: rtl/padded_frame_rotate_90_top.sv
// an accepted emit beat is read into the read stage, then into the result register
// throughput: one beat per cycle, load or emit, while no resync runs and results drain
// a register write holds off request beats while the resync states, divide then
// multiply, re-derive the read address counters from the column index
// reset (synchronous) clears counters and restores register defaults;
// the frame store is not cleared
// ----------------------------------------------------------------------------
// padded_frame_rotate_90_top
// Loads a padded bitmap into a frame store and emits it rotated by 90 degrees.
// ----------------------------------------------------------------------------
module padded_frame_rotate_90_top
   import pfr_pkg::*;
#(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF,
   parameter int FRAME_BYTES   = FRAME_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   pfr_req_if.sink           req,
   pfr_rsp_if.source         rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int AW   = $clog2(FRAME_BYTES);
   localparam int LC_W = $clog2(FRAME_BYTES + 1);
   localparam logic [CALC_W-1:0] FRAME_LIM = CALC_W'(FRAME_BYTES);

   csr_out_type cfg;

   pfr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // geometry
   logic [REG_W-1:0]  w_eff, h_eff;
   logic [BPP_W-1:0]  bpp_eff;
   logic [GEO_W-1:0]  wb, hb, row_size, new_row;
   logic [CALC_W-1:0] frame_sz;

   assign w_eff    = clamp_dim(cfg.image_width, MAX_DIMENSION);
   assign h_eff    = clamp_dim(cfg.image_height, MAX_DIMENSION);
   assign bpp_eff  = eff_bpp(cfg.bytes_per_pixel);
   assign wb       = GEO_W'(w_eff) * GEO_W'(bpp_eff);
   assign hb       = GEO_W'(h_eff) * GEO_W'(bpp_eff);
   assign row_size = (wb + GEO_W'(3)) & ~GEO_W'(3);
   assign new_row  = (hb + GEO_W'(3)) & ~GEO_W'(3);
   assign frame_sz = CALC_W'(row_size) * CALC_W'(h_eff);

   // counters
   logic [LC_W-1:0]   lc_ff, lc_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [YW-1:0]     y_ff, y_in;
   logic [1:0]        comp_ff, comp_in;
   logic [CALC_W-1:0] ybase_ff, ybase_in;
   resync_state_type  rs_state_ff, rs_state_in;

   // pipeline
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_hit_ff, s1_hit_in;
   logic       s1_last_ff, s1_last_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_last_ff, rsp_last_in;
   logic [7:0] ram_rdata;

   logic              acc, acc_emit, acc_load, load_ok, s1_adv, rs_idle;
   logic              in_geom, rd_hit, row_end, frame_last, comp_wrap;
   logic [REG_W-1:0]  xoff;
   logic [GEO_W-1:0]  xoff_b;
   logic [CALC_W-1:0] rd_addr;

   // re-derivation of pixel index and component from the column
   logic [2*COL_W-1:0] prod3;
   logic [YW-1:0]      y_div;
   logic [GEO_W-1:0]   y_mul_b;
   logic [COL_W-1:0]   comp_re;
   logic [CALC_W-1:0]  ybase_re;

   assign acc      = req.valid && req.ready;
   assign acc_emit = acc && req.op;
   assign acc_load = acc && !req.op;
   assign s1_adv   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = rs_idle && (!s1_valid_ff || s1_adv);

   assign load_ok = (CALC_W'(lc_ff) < frame_sz) && (CALC_W'(lc_ff) < FRAME_LIM);

   assign in_geom    = (row_ff < w_eff) && (GEO_W'(col_ff) < hb);
   assign xoff       = w_eff - REG_W'(1) - row_ff;
   assign xoff_b     = GEO_W'(xoff) * GEO_W'(bpp_eff);
   assign rd_addr    = ybase_ff + CALC_W'(xoff_b) + CALC_W'(comp_ff);
   assign rd_hit     = in_geom && (rd_addr < FRAME_LIM);
   assign row_end    = (GEO_W'(col_ff) + GEO_W'(1)) >= new_row;
   assign frame_last = row_end && ((GEO_W'(row_ff) + GEO_W'(1)) >= GEO_W'(w_eff));
   assign comp_wrap  = (BPP_W'(comp_ff) + BPP_W'(1)) == bpp_eff;

   assign prod3    = (2*COL_W)'(col_ff) * (2*COL_W)'(RECIP3);
   assign y_mul_b  = GEO_W'(y_ff) * GEO_W'(bpp_eff);
   assign comp_re  = col_ff - y_mul_b[COL_W-1:0];
   assign ybase_re = CALC_W'(y_ff) * CALC_W'(row_size);

   always_comb begin
      case (bpp_eff)
         3'd1:    y_div = YW'(col_ff);
         3'd2:    y_div = YW'(col_ff >> 1);
         3'd3:    y_div = YW'(prod3[2*COL_W-1:RECIP3_SHIFT]);
         default: y_div = YW'(col_ff >> 2);
      endcase
   end

   // resync sequencer: divide, then multiply
   always_comb begin
      rs_state_in = rs_state_ff;
      rs_idle     = 1'b0;
      case (rs_state_ff)
         RS_IDLE: begin
            rs_idle = 1'b1;
            if (cfg.written) begin
               rs_state_in = RS_DIV;
            end
         end
         RS_DIV:  rs_state_in = RS_MUL;
         RS_MUL:  rs_state_in = cfg.written ? RS_DIV : RS_IDLE;
         default: rs_state_in = RS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rs_state_ff <= RS_IDLE;
      end else begin
         rs_state_ff <= rs_state_in;
      end
   end

   always_comb begin
      lc_in    = lc_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      y_in     = y_ff;
      comp_in  = comp_ff;
      ybase_in = ybase_ff;
      if (rs_state_ff == RS_DIV) begin
         y_in = y_div;
      end
      if (rs_state_ff == RS_MUL) begin
         comp_in  = comp_re[1:0];
         ybase_in = ybase_re;
      end
      if (acc_load && load_ok) begin
         lc_in = lc_ff + LC_W'(1);
      end
      if (acc_emit) begin
         if (frame_last) begin
            lc_in    = '0;
            row_in   = '0;
            col_in   = '0;
            y_in     = '0;
            comp_in  = '0;
            ybase_in = '0;
         end else if (row_end) begin
            row_in   = row_ff + ROW_W'(1);
            col_in   = '0;
            y_in     = '0;
            comp_in  = '0;
            ybase_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
            if (comp_wrap) begin
               // next pixel of the source column
               comp_in  = '0;
               y_in     = y_ff + YW'(1);
               ybase_in = ybase_ff + CALC_W'(row_size);
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff    <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         y_ff     <= '0;
         comp_ff  <= '0;
         ybase_ff <= '0;
      end else begin
         lc_ff    <= lc_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         y_ff     <= y_in;
         comp_ff  <= comp_in;
         ybase_ff <= ybase_in;
      end
   end

   pfr_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_BYTES)
   ) u_frame_store (
      .clock (clock),
      .we    (acc_load && load_ok),
      .waddr (lc_ff[AW-1:0]),
      .wdata (req.source_byte),
      .re    (acc_emit && rd_hit),
      .raddr (rd_addr[AW-1:0]),
      .rdata (ram_rdata)
   );

   // read stage and result register; ram data holds while the read stage stalls
   always_comb begin
      s1_valid_in  = acc_emit ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_hit_in    = acc_emit ? rd_hit : s1_hit_ff;
      s1_last_in   = acc_emit ? frame_last : s1_last_ff;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (s1_adv) begin
         // padding and out of frame positions read as zero
         rsp_byte_in = s1_hit_ff ? ram_rdata : 8'd0;
         rsp_last_in = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_hit_ff   <= s1_hit_in;
      s1_last_ff  <= s1_last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.rotated_byte = rsp_byte_ff;
   assign rsp.last_byte    = rsp_last_ff;

`ifndef SYNTH
   a_emit_fills_stage: assert property (@(posedge clock) disable iff (reset)
      acc_emit |=> s1_valid_ff)
      else $error("emit beat did not reach the read stage");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (acc_emit && frame_last) |=> (row_ff == '0 && col_ff == '0 && lc_ff == '0))
      else $error("frame counters not cleared after last byte");

   a_resync_blocks: assert property (@(posedge clock) disable iff (reset)
      (rs_state_ff != RS_IDLE) |-> !req.ready)
      else $error("request beat taken during counter resync");

   a_comp_range: assert property (@(posedge clock) disable iff (reset)
      (rs_state_ff == RS_IDLE && !$past(cfg.written)) |-> (BPP_W'(comp_ff) < bpp_eff))
      else $error("component counter out of pixel range");
`endif

endmodule

FILE: rtl/pfr_ram.sv
// ----------------------------------------------------------------------------
// pfr_ram
// Generic simple dual port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/pfr_csr.sv
// ----------------------------------------------------------------------------
// pfr_csr
// APB style register file: image width, image height, bytes per pixel.
// ----------------------------------------------------------------------------
module pfr_csr
   import pfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output csr_out_type       cfg
);

   logic [REG_W-1:0] width_ff, width_in;
   logic [REG_W-1:0] height_ff, height_in;
   logic [BPP_W-1:0] bpp_ff, bpp_in;
   logic             wr;
   logic [1:0]       idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign idx = csr_paddr[3:2];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      bpp_in    = bpp_ff;
      if (wr) begin
         case (idx)
            REG_IMAGE_WIDTH:     width_in  = csr_pwdata[REG_W-1:0];
            REG_IMAGE_HEIGHT:    height_in = csr_pwdata[REG_W-1:0];
            REG_BYTES_PER_PIXEL: bpp_in    = csr_pwdata[BPP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RESET;
         height_ff <= IMAGE_HEIGHT_RESET;
         bpp_ff    <= BYTES_PER_PIXEL_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
      end
   end

   always_comb begin
      case (idx)
         REG_IMAGE_WIDTH:     csr_prdata = CSR_DW'(width_ff);
         REG_IMAGE_HEIGHT:    csr_prdata = CSR_DW'(height_ff);
         REG_BYTES_PER_PIXEL: csr_prdata = CSR_DW'(bpp_ff);
         default:             csr_prdata = '0;
      endcase
   end

   assign cfg.image_width     = width_ff;
   assign cfg.image_height    = height_ff;
   assign cfg.bytes_per_pixel = bpp_ff;
   assign cfg.written         = wr;

endmodule

FILE: test/tb_padded_frame_rotate_90_top.sv
// ----------------------------------------------------------------------------
// tb_padded_frame_rotate_90_top
// Self-checking bench for the 90 degree frame rotator. Request beats load
// padded source bytes and ask for rotated bytes; a shadow frame store and
// counters in the bench work out each rotated byte and its last flag, and
// every result beat is compared with the oldest one still owed. Geometry is
// changed over the APB port between frames and now and then mid-frame.
// ----------------------------------------------------------------------------
module tb_padded_frame_rotate_90_top
   import pfr_pkg::*;
();

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   localparam int RANDOM_BEATS = 380;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 1500000;
   // the warm-up frame writes this many store bytes; later frames stay inside them
   localparam int WARM_BYTES   = 64;

   typedef struct packed {
      logic       op;
      logic [7:0] source_byte;
   } request_beat_type;

   typedef struct packed {
      logic [7:0] rotated_byte;
      logic       last_byte;
   } rotated_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_op = OP_LOAD;
   logic [7:0]        req_source_byte = '0;
   logic              rsp_ready = 1'b0;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   pfr_req_if req_if ();
   pfr_rsp_if rsp_if ();

   assign req_if.valid       = req_valid;
   assign req_if.op          = req_op;
   assign req_if.source_byte = req_source_byte;
   assign rsp_if.ready       = rsp_ready;

   padded_frame_rotate_90_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // register copies as the block holds them
   logic [REG_W-1:0] geo_width  = IMAGE_WIDTH_RESET;
   logic [REG_W-1:0] geo_height = IMAGE_HEIGHT_RESET;
   logic [BPP_W-1:0] geo_bpp    = BYTES_PER_PIXEL_RESET;

   // shadow frame store and read counters
   logic [7:0] frame_copy [FRAME_BYTES_DEF];
   int         load_fill;
   int         out_row;
   int         out_column;

   request_beat_type request_beats [$];
   rotated_beat_type rotated_due [$];
   int               beats_queued;
   int               beats_taken;
   int               errors;
   int               cycle_count;
   int               hold_ask;
   logic             req_taken = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic frame_geometry(input logic [REG_W-1:0] raw_w, input logic [REG_W-1:0] raw_h,
                                 input logic [BPP_W-1:0] raw_b, output int w, output int h,
                                 output int bpp, output int src_row, output int rot_row);
      w = (raw_w == 0) ? 1 : ((raw_w > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : int'(raw_w));
      h = (raw_h == 0) ? 1 : ((raw_h > MAX_DIMENSION_DEF) ? MAX_DIMENSION_DEF : int'(raw_h));
      bpp = (raw_b == 0) ? 1 : ((raw_b > 4) ? 4 : int'(raw_b));
      src_row = ((w * bpp * 8 + 31) / 32) * 4;
      rot_row = ((h * bpp * 8 + 31) / 32) * 4;
   endtask

   function automatic int idle_gap(inout int run_left);
      int pick;
      int gap;
      if (run_left > 0) begin
         run_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         // stretch with no idling
         run_left = $urandom_range(30, 120);
         gap = 0;
      end else if (pick < 65) begin
         gap = 0;
      end else if (pick < 95) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 30);
      end
      return gap;
   endfunction

   // request side: one beat on the bus at a time, gaps after each beat
   always @(negedge clock) begin : feed_requests
      request_beat_type nxt;
      int               req_gap;
      int               req_run;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (request_beats.size() != 0) begin
            nxt = request_beats.pop_front();
            req_valid       <= 1'b1;
            req_op          <= nxt.op;
            req_source_byte <= nxt.source_byte;
            req_gap = idle_gap(req_run);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random stalls, plus one long hold at the first result after a hold is asked
   always @(negedge clock) begin : drain_results
      int hold_seen;
      int hold_left;
      int rsp_gap;
      int rsp_run;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_ask && rsp_if.valid) begin
         hold_seen = hold_ask;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         rsp_gap = idle_gap(rsp_run);
      end
   end

   always @(posedge clock) begin : watch_beats
      int               w;
      int               h;
      int               bpp;
      int               src_row;
      int               rot_row;
      int               fill_limit;
      int               addr;
      logic             row_end;
      rotated_beat_type want;
      rotated_beat_type got;
      if (reset) begin
         req_taken <= 1'b0;
         load_fill     = 0;
         out_row       = 0;
         out_column    = 0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready) begin
            beats_taken++;
            frame_geometry(geo_width, geo_height, geo_bpp, w, h, bpp, src_row, rot_row);
            if (req_if.op == OP_LOAD) begin
               fill_limit = src_row * h;
               if (fill_limit > FRAME_BYTES_DEF) fill_limit = FRAME_BYTES_DEF;
               if (load_fill < fill_limit) begin
                  frame_copy[load_fill] = req_if.source_byte;
                  load_fill++;
               end
            end else begin
               want.rotated_byte = '0;
               // positions outside the rotated pixels are padding
               if (out_row < w && out_column < h * bpp) begin
                  addr = (out_column / bpp) * src_row + (w - 1 - out_row) * bpp
                         + out_column % bpp;
                  if (addr < FRAME_BYTES_DEF) want.rotated_byte = frame_copy[addr];
               end
               row_end = (out_column + 1 >= rot_row);
               want.last_byte = row_end && (out_row + 1 >= w);
               if (want.last_byte) begin
                  load_fill     = 0;
                  out_row       = 0;
                  out_column    = 0;
               end else if (row_end) begin
                  out_row++;
                  out_column    = 0;
               end else begin
                  out_column++;
               end
               rotated_due.push_back(want);
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            got.rotated_byte = rsp_if.rotated_byte;
            got.last_byte    = rsp_if.last_byte;
            if (rotated_due.size() == 0) begin
               $error("result beat with none owed: rotated_byte %0h last_byte %0b",
                      got.rotated_byte, got.last_byte);
               errors++;
            end else begin
               want = rotated_due.pop_front();
               if (got.rotated_byte !== want.rotated_byte) begin
                  $error("rotated_byte: expected %0h, actual %0h",
                         want.rotated_byte, got.rotated_byte);
                  errors++;
               end
               if (got.last_byte !== want.last_byte) begin
                  $error("last_byte: expected %0b, actual %0b", want.last_byte, got.last_byte);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // stimulus tasks are entered and left on a rising edge
   task automatic queue_beat(input logic beat_op, input logic [7:0] data);
      request_beats.push_back('{beat_op, data});
      beats_queued++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (beats_taken != beats_queued || rotated_due.size() != 0) @(negedge clock);
      // loads leave nothing owed, so give the pipe time to settle
      repeat (4) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [CSR_DW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (index)
         REG_IMAGE_WIDTH:     geo_width  = value[REG_W-1:0];
         REG_IMAGE_HEIGHT:    geo_height = value[REG_W-1:0];
         REG_BYTES_PER_PIXEL: geo_bpp    = value[BPP_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [REG_W-1:0] raw_w, input logic [REG_W-1:0] raw_h,
                               input logic [BPP_W-1:0] raw_b);
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, CSR_DW'(raw_w));
      write_reg(REG_IMAGE_HEIGHT, CSR_DW'(raw_h));
      write_reg(REG_BYTES_PER_PIXEL, CSR_DW'(raw_b));
   endtask

   task automatic pick_geometry();
      logic [REG_W-1:0] raw_w;
      logic [REG_W-1:0] raw_h;
      logic [BPP_W-1:0] raw_b;
      int               w;
      int               h;
      int               bpp;
      int               src_row;
      int               rot_row;
      do begin
         raw_w = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(1, 5));
         raw_h = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(1, 5));
         raw_b = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7))
                                             : 3'($urandom_range(1, 4));
         frame_geometry(raw_w, raw_h, raw_b, w, h, bpp, src_row, rot_row);
      end while (src_row * h > WARM_BYTES);
      set_geometry(raw_w, raw_h, raw_b);
   endtask

   // whole frame: every source byte, optional dropped loads, every rotated byte
   task automatic send_frame(input int dropped_loads, output int beats);
      int w;
      int h;
      int bpp;
      int src_row;
      int rot_row;
      frame_geometry(geo_width, geo_height, geo_bpp, w, h, bpp, src_row, rot_row);
      for (int k = 0; k < src_row * h; k++) queue_beat(OP_LOAD, 8'($urandom_range(0, 255)));
      repeat (dropped_loads) queue_beat(OP_LOAD, 8'($urandom_range(0, 255)));
      for (int k = 0; k < rot_row * w; k++) queue_beat(OP_EMIT, 8'($urandom_range(0, 255)));
      beats = src_row * h + rot_row * w;
   endtask

   // emit up to the last byte from wherever the counters stand
   task automatic finish_frame(output int beats);
      int   w;
      int   h;
      int   bpp;
      int   src_row;
      int   rot_row;
      int   r;
      int   c;
      logic done;
      wait_drained();
      frame_geometry(geo_width, geo_height, geo_bpp, w, h, bpp, src_row, rot_row);
      r = out_row;
      c = out_column;
      beats = 0;
      done = 1'b0;
      while (!done) begin
         beats++;
         if (c + 1 >= rot_row) begin
            if (r + 1 >= w) done = 1'b1;
            else begin
               r++;
               c = 0;
            end
         end else begin
            c++;
         end
      end
      repeat (beats) queue_beat(OP_EMIT, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      int random_beats;
      int beats;
      int kind;
      int w;
      int h;
      int bpp;
      int src_row;
      int rot_row;
      int n;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset geometry: one 3-byte pixel plus one pad byte
      queue_beat(OP_LOAD, 8'h00);
      queue_beat(OP_LOAD, 8'hFF);
      queue_beat(OP_LOAD, 8'hA5);
      queue_beat(OP_LOAD, 8'h5A);
      // past the end of the frame, dropped
      queue_beat(OP_LOAD, 8'h3C);
      queue_beat(OP_LOAD, 8'hC3);
      repeat (4) queue_beat(OP_EMIT, 8'hFF);

      // zero width and zero bytes per pixel act as one, two source rows
      set_geometry(8'd0, 8'd2, 3'd0);
      for (int k = 0; k < 8; k++) queue_beat(OP_LOAD, 8'(k * 37 + 1));
      repeat (4) queue_beat(OP_EMIT, 8'h00);

      // store warm-up at four bytes per pixel, with the result side held off
      set_geometry(8'd16, 8'd1, 3'd7);
      hold_ask++;
      send_frame(0, beats);

      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         if ($urandom_range(0, 1) == 0) pick_geometry();
         frame_geometry(geo_width, geo_height, geo_bpp, w, h, bpp, src_row, rot_row);
         kind = $urandom_range(0, 99);
         if (kind < 75) begin
            send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0, beats);
            random_beats += beats;
         end else if (kind < 85) begin
            // rotated reads mixed into a partial load
            n = $urandom_range(1, src_row * h);
            for (int k = 0; k < n; k++) begin
               queue_beat(($urandom_range(0, 3) == 0) ? OP_EMIT : OP_LOAD,
                          8'($urandom_range(0, 255)));
            end
            finish_frame(beats);
            random_beats += n + beats;
         end else if (kind < 93) begin
            // geometry changed with the read counters part way through
            for (int k = 0; k < src_row * h; k++) begin
               queue_beat(OP_LOAD, 8'($urandom_range(0, 255)));
            end
            n = $urandom_range(1, rot_row * w);
            repeat (n) queue_beat(OP_EMIT, 8'($urandom_range(0, 255)));
            pick_geometry();
            finish_frame(beats);
            random_beats += src_row * h + n + beats;
         end else begin
            n = $urandom_range(1, 20);
            for (int k = 0; k < n; k++) begin
               queue_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
            finish_frame(beats);
            random_beats += n + beats;
         end
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/pfr_pkg.sv
rtl/pfr_if.sv
rtl/pfr_ram.sv
rtl/pfr_csr.sv
rtl/padded_frame_rotate_90_top.sv
test/tb_padded_frame_rotate_90_top.sv
